// File: rtl/core/lattice_allpass_filter_core_assert.svh
// Assertion macros for the allpass filter core.
`ifndef LATTICE_ALLPASS_FILTER_CORE_ASSERT_SVH
`define LATTICE_ALLPASS_FILTER_CORE_ASSERT_SVH

`ifndef SYNTH
// checked outside reset
`define LAP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked at every edge, reset included
`define LAP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define LAP_ASSERT(lbl, prop, msg)
`define LAP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/core/lap_pkg.sv
`default_nettype none

package lap_pkg;

   localparam int DELAY_WIDTH = 11;
   localparam int COEFF_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEFF = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DELAY_LENGTH = 2'd1;

   localparam logic MODE_FILTER = 1'b0;
   localparam logic MODE_TAP = 1'b1;

   localparam logic signed [COEFF_WIDTH-1:0] COEFF_RESET = 16'sd16384;
   localparam logic [DELAY_WIDTH-1:0] DELAY_LENGTH_RESET = 11'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_WRITE,
      ST_MUL2,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;   // latch input, read delay line
      logic mul1;      // d * -coeff
      logic write;     // form w, store it, advance pointer
      logic mul2;      // w * coeff
      logic load;      // result into output register
   } cmd_type;

endpackage

`default_nettype wire

// File: rtl/core/lattice_allpass_filter_core.sv
// Filter sample (mode 0): capture, mul1, write, mul2 and load steps in that order; the next input
// is taken only after the result is loaded, and the load waits while the output is stalled. One
// sample at a time passes the sequencer (read, two multiply/round steps and the write share one
// memory port and one pass through the FSM). Tap read (mode 1): capture then load, one at a time.
// Synchronous reset: coeff 0.5, delay_length 1, write pointer and fill count zero; unwritten
// delay entries read as zero through the fill count, so no clearing pass is needed.
`default_nettype none

module lattice_allpass_filter_core #(
   parameter int MAX_DELAY = 1024,
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // tdata: sample [SAMPLE_WIDTH-1:0], tap_delay [SAMPLE_WIDTH+10:SAMPLE_WIDTH], zero pad
   input  wire logic [((SAMPLE_WIDTH+18)/8)*8-1:0]  req_tdata,
   // tuser: mode [0]
   input  wire logic [0:0]                          req_tuser,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // tdata: value [SAMPLE_WIDTH-1:0], zero pad
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        rsp_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lap_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [lap_pkg::COEFF_WIDTH-1:0]     csr_data
);
   import lap_pkg::*;

   localparam int RSP_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

   cmd_type                         cmd;
   logic signed [SAMPLE_WIDTH-1:0]  value;

   assign csr_ready = 1'b1;

   lap_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_tuser[0]),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   lap_datapath #(
      .MAX_DELAY    (MAX_DELAY),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .csr_we       (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .in_mode      (req_tuser[0]),
      .in_sample    ($signed(req_tdata[SAMPLE_WIDTH-1:0])),
      .in_tap_delay (req_tdata[SAMPLE_WIDTH+DELAY_WIDTH-1:SAMPLE_WIDTH]),
      .out_value    (value)
   );

   assign rsp_tdata = RSP_W'($unsigned(value));

`include "lattice_allpass_filter_core_assert.svh"

   `LAP_ASSERT(a_no_overwrite, cmd.load |-> (!rsp_tvalid || rsp_tready), "result overwritten while stalled")
   `LAP_ASSERT(a_write_follows, (req_tvalid && req_tready && req_tuser[0] == MODE_FILTER) |-> ##2 cmd.write, "filter transfer did not reach write step")
   `LAP_ASSERT(a_busy_blocks, (cmd.mul1 || cmd.write || cmd.mul2) |-> !req_tready, "input taken while busy")
   `LAP_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

`default_nettype wire

// File: rtl/core/lap_ctrl.sv
`default_nettype none

module lap_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic             req_mode,
   output logic                  req_tready,
   input  wire logic             rsp_tready,
   output logic                  rsp_tvalid,
   output lap_pkg::cmd_type      cmd
);
   import lap_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in = (req_mode == MODE_TAP) ? ST_DONE : ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register can take the result
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid_in = cmd.load || (rsp_tvalid_ff && !rsp_tready);
   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

`default_nettype wire

// File: rtl/core/lap_datapath.sv
`default_nettype none

module lap_datapath #(
   parameter int MAX_DELAY = 1024,
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire lap_pkg::cmd_type                     cmd,
   input  wire logic                                 csr_we,
   input  wire logic [lap_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [lap_pkg::COEFF_WIDTH-1:0]      csr_data,
   input  wire logic                                 in_mode,
   input  wire logic signed [SAMPLE_WIDTH-1:0]       in_sample,
   input  wire logic [lap_pkg::DELAY_WIDTH-1:0]      in_tap_delay,
   output logic signed [SAMPLE_WIDTH-1:0]            out_value
);
   import lap_pkg::*;

   localparam int SW = SAMPLE_WIDTH;
   localparam int ADDR_W = $clog2(MAX_DELAY);
   localparam int DLY_W = $clog2(MAX_DELAY + 1);
   localparam int SUM_W = DLY_W + 1;
   localparam int P1_W = SW + 17;
   localparam int P2_W = SW + COEFF_WIDTH;
   localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

   logic signed [SW-1:0] mem [MAX_DELAY];

   logic signed [COEFF_WIDTH-1:0] coeff_ff;
   logic [DELAY_WIDTH-1:0]        delay_length_ff;
   logic [ADDR_W-1:0]             wp_ff;
   logic [DLY_W-1:0]              fill_ff;
   logic                          mode_ff;
   logic signed [SW-1:0]          x_ff;
   logic signed [SW-1:0]          rd_ff;
   logic                          rd_valid_ff, rd_valid_in;
   logic signed [P1_W-1:0]        p1_ff, p1_in;
   logic signed [SW-1:0]          w_ff, w_in;
   logic signed [P2_W-1:0]        p2_ff, p2_in;
   logic signed [SW-1:0]          out_ff, out_in;

   logic [DELAY_WIDTH-1:0]        d_raw;
   logic [31:0]                   d_wide;
   logic [DLY_W-1:0]              d_clamp;
   logic [SUM_W-1:0]              addr_sum;
   logic [ADDR_W-1:0]             rd_addr;
   logic signed [SW-1:0]          d_val;
   logic signed [16:0]            ncoeff;
   logic signed [SW+17:0]         t1;
   logic signed [SW+2:0]          r1;
   logic signed [SW+3:0]          s1;
   logic signed [SW+16:0]         t2;
   logic signed [SW+1:0]          r2;
   logic signed [SW+2:0]          s2;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= COEFF_RESET;
         delay_length_ff <= DELAY_LENGTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COEFF:        coeff_ff <= $signed(csr_data);
            CSR_DELAY_LENGTH: delay_length_ff <= csr_data[DELAY_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // read address: clamp delay to 1..MAX_DELAY, then wrap behind the pointer
   always_comb begin
      d_raw = (in_mode == MODE_TAP) ? in_tap_delay : delay_length_ff;
      d_wide = 32'(d_raw);
      if (d_wide == 32'd0) begin
         d_wide = 32'd1;
      end else if (d_wide > 32'(MAX_DELAY)) begin
         d_wide = 32'(MAX_DELAY);
      end
      d_clamp = d_wide[DLY_W-1:0];
      addr_sum = SUM_W'(wp_ff) + SUM_W'(MAX_DELAY) - SUM_W'(d_clamp);
      if (addr_sum >= SUM_W'(MAX_DELAY)) begin
         addr_sum = addr_sum - SUM_W'(MAX_DELAY);
      end
      rd_addr = addr_sum[ADDR_W-1:0];
      // entries not yet written since reset read as zero
      rd_valid_in = (d_clamp <= fill_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_ff <= mem[rd_addr];
      end
      if (cmd.write) begin
         mem[wp_ff] <= w_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         fill_ff <= '0;
      end else if (cmd.write) begin
         wp_ff <= (wp_ff == ADDR_W'(MAX_DELAY - 1)) ? '0 : wp_ff + 1'b1;
         if (fill_ff != DLY_W'(MAX_DELAY)) begin
            fill_ff <= fill_ff + 1'b1;
         end
      end
   end

   assign d_val = rd_valid_ff ? rd_ff : '0;
   assign ncoeff = -$signed({coeff_ff[COEFF_WIDTH-1], coeff_ff});
   assign p1_in = d_val * ncoeff;
   assign p2_in = w_ff * coeff_ff;

   // round to nearest, ties up: floor((p + 2^14) / 2^15)
   always_comb begin
      t1 = $signed({p1_ff[P1_W-1], p1_ff}) + (SW+18)'(16384);
      r1 = t1[SW+17:15];
      s1 = (SW+4)'(x_ff) + (SW+4)'(r1);
      if (s1 > (SW+4)'(S_MAX)) begin
         w_in = S_MAX;
      end else if (s1 < (SW+4)'(S_MIN)) begin
         w_in = S_MIN;
      end else begin
         w_in = s1[SW-1:0];
      end

      t2 = $signed({p2_ff[P2_W-1], p2_ff}) + (SW+17)'(16384);
      r2 = t2[SW+16:15];
      s2 = (SW+3)'(d_val) + (SW+3)'(r2);
      if (mode_ff == MODE_TAP) begin
         out_in = d_val;
      end else if (s2 > (SW+3)'(S_MAX)) begin
         out_in = S_MAX;
      end else if (s2 < (SW+3)'(S_MIN)) begin
         out_in = S_MIN;
      end else begin
         out_in = s2[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= in_mode;
         x_ff <= in_sample;
         rd_valid_ff <= rd_valid_in;
      end
      if (cmd.mul1) begin
         p1_ff <= p1_in;
      end
      if (cmd.write) begin
         w_ff <= w_in;
      end
      if (cmd.mul2) begin
         p2_ff <= p2_in;
      end
      if (cmd.load) begin
         out_ff <= out_in;
      end
   end

   assign out_value = out_ff;

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import lap_pkg::*;

   localparam int LINE_DEPTH = 1024;
   localparam int NUM_PHASES = 10;
   localparam int PHASE_ITEMS = 130;
   localparam int HOLD_OFF_AFTER = 400;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int CYCLE_LIMIT = 400000;

   typedef enum logic [1:0] {ROW_FILTER, ROW_TAP, ROW_COEFF, ROW_DELAY} row_kind_type;

   // value is the sample for items and the write data for register rows
   typedef struct packed {
      row_kind_type kind;
      logic [15:0]  value;
      logic [10:0]  tap;
      logic         pinned;
      logic [15:0]  exp_value;
   } dir_row_type;

   typedef struct packed {
      logic        pinned;
      logic [15:0] value;
   } pin_type;

   localparam int DIR_ROWS = 26;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic [31:0]                req_tdata = '0;   // sample [15:0], tap_delay [26:16], zero pad
   logic [0:0]                 req_tuser = '0;   // mode [0]
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [15:0]                rsp_tdata;        // value [15:0]
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [15:0]                csr_data = '0;

   // filter state as predicted from the accepted transfers
   logic signed [15:0] line_store [LINE_DEPTH];
   logic [9:0]         wr_ptr = '0;
   longint             coeff_q = COEFF_RESET;
   logic [10:0]        dlen_q = DELAY_LENGTH_RESET;

   logic [15:0] pending_outputs [$];
   pin_type     pinned_q [$];

   int errors = 0;
   int results_seen = 0;
   int filter_count = 0;
   int tap_count = 0;
   int csr_writes = 0;
   int cycle_count = 0;

   dir_row_type directed_rows [DIR_ROWS] = '{
      '{ROW_TAP,    16'h5A5A, 11'd1,    1'b1, 16'h0000},
      '{ROW_TAP,    16'hA5A5, 11'd0,    1'b1, 16'h0000},
      '{ROW_TAP,    16'h0000, 11'd2047, 1'b1, 16'h0000},
      '{ROW_FILTER, 16'h0000, 11'h7FF,  1'b1, 16'h0000},
      '{ROW_FILTER, 16'h7FFF, 11'd0,    1'b0, 16'h0000},
      '{ROW_TAP,    16'h0000, 11'd1,    1'b1, 16'h7FFF},
      '{ROW_FILTER, 16'h8000, 11'h400,  1'b0, 16'h0000},
      '{ROW_TAP,    16'hFFFF, 11'd1,    1'b1, 16'h8000},
      '{ROW_COEFF,  16'h8000, 11'd0,    1'b0, 16'h0000},
      '{ROW_DELAY,  16'h0000, 11'd0,    1'b0, 16'h0000},
      '{ROW_FILTER, 16'h7FFF, 11'd5,    1'b0, 16'h0000},
      '{ROW_FILTER, 16'h8000, 11'd9,    1'b0, 16'h0000},
      '{ROW_DELAY,  16'hFFFF, 11'd0,    1'b0, 16'h0000},
      '{ROW_FILTER, 16'd12345, 11'd0,   1'b0, 16'h0000},
      '{ROW_COEFF,  16'h7FFF, 11'd0,    1'b0, 16'h0000},
      '{ROW_DELAY,  16'd1024, 11'd0,    1'b0, 16'h0000},
      '{ROW_FILTER, 16'hFFFF, 11'd3,    1'b0, 16'h0000},
      '{ROW_TAP,    16'h1234, 11'd1024, 1'b0, 16'h0000},
      '{ROW_TAP,    16'h0000, 11'd1025, 1'b0, 16'h0000},
      '{ROW_COEFF,  16'h0000, 11'd0,    1'b0, 16'h0000},
      '{ROW_DELAY,  16'd3,    11'd0,    1'b0, 16'h0000},
      '{ROW_FILTER, 16'd100,  11'd77,   1'b0, 16'h0000},
      '{ROW_FILTER, 16'hFF9C, 11'd0,    1'b0, 16'h0000},
      '{ROW_FILTER, 16'd7,    11'd2000, 1'b0, 16'h0000},
      // coefficient zero passes x straight into the line
      '{ROW_TAP,    16'h0F0F, 11'd3,    1'b1, 16'd100},
      '{ROW_COEFF,  16'd16384, 11'd0,   1'b0, 16'h0000}
   };

   lattice_allpass_filter_core #(
      .MAX_DELAY(LINE_DEPTH),
      .SAMPLE_WIDTH(16)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   function automatic int unsigned effective_delay(logic [10:0] d);
      if (d == 0) return 1;
      if (d > LINE_DEPTH) return LINE_DEPTH;
      return d;
   endfunction

   // floor((p + 0.5 lsb) / 2^15): nearest, ties toward +inf
   function automatic longint round_q15(longint p);
      return (p + 16384) >>> 15;
   endfunction

   function automatic longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic logic [15:0] allpass_step(logic mode, logic signed [15:0] x,
                                                logic [10:0] tap);
      logic [9:0] rd_idx;
      longint     dv;
      longint     w;
      if (mode == MODE_TAP) begin
         rd_idx = wr_ptr - 10'(effective_delay(tap));
         return line_store[rd_idx];
      end
      // a delay of the full depth reads the slot about to be overwritten
      rd_idx = wr_ptr - 10'(effective_delay(dlen_q));
      dv = longint'(line_store[rd_idx]);
      w = clip16(longint'(x) + round_q15(dv * -coeff_q));
      line_store[wr_ptr] = 16'(w);
      wr_ptr = wr_ptr + 10'd1;
      return 16'(clip16(dv + round_q15(w * coeff_q)));
   endfunction

   function automatic int idle_len();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 5) return 0;
      if (roll < 9) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin : scoreboard
      logic [15:0] want;
      logic [15:0] model_value;
      pin_type     pin;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            csr_writes++;
            if (csr_index == CSR_COEFF) begin
               coeff_q = longint'($signed(csr_data));
            end else if (csr_index == CSR_DELAY_LENGTH) begin
               dlen_q = csr_data[10:0];
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (pending_outputs.size() == 0) begin
               errors++;
               $display("%0t: result with nothing expected, actual %h", $time, rsp_tdata);
            end else begin
               want = pending_outputs.pop_front();
               if (rsp_tdata !== want) begin
                  errors++;
                  $display("%0t: value mismatch, expected %h actual %h", $time, want,
                           rsp_tdata);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == MODE_TAP) tap_count++;
            else filter_count++;
            model_value = allpass_step(req_tuser[0], req_tdata[15:0], req_tdata[26:16]);
            pin = pinned_q.pop_front();
            pending_outputs.push_back(pin.pinned ? pin.value : model_value);
         end
      end
   end

   task automatic send_item(logic mode, logic [15:0] smp, logic [10:0] tap, logic pinned,
                            logic [15:0] pin_value, int gap);
      pinned_q.push_back(pin_type'{pinned, pin_value});
      req_tdata <= {5'd0, tap, smp};
      req_tuser <= mode;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [15:0] data);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // stop offering and wait for every outstanding result; an item counts
   // from the moment it is offered until its result is taken
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_outputs.size() + pinned_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin : result_sink
      bit held_off;
      int run;
      int stall;
      held_off = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && results_seen >= HOLD_OFF_AFTER) begin
            // long back-pressure so the core fills and stalls its input
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            held_off = 1'b1;
         end
         run = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
         rsp_tready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = idle_len();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("tb_top: errors");
      $finish;
   end

   initial begin : stimulus
      dir_row_type row;
      logic        mode;
      logic [15:0] smp;
      logic [15:0] coeff_word;
      logic [10:0] dly;
      logic [10:0] tap;
      bit          steady;
      for (int i = 0; i < LINE_DEPTH; i++) line_store[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIR_ROWS; r++) begin
         row = directed_rows[r];
         case (row.kind)
            ROW_FILTER: send_item(MODE_FILTER, row.value, row.tap, row.pinned, row.exp_value,
                                  idle_len());
            ROW_TAP:    send_item(MODE_TAP, row.value, row.tap, row.pinned, row.exp_value,
                                  idle_len());
            ROW_COEFF: begin
               settle();
               write_reg(CSR_COEFF, row.value);
            end
            default: begin
               settle();
               write_reg(CSR_DELAY_LENGTH, row.value);
            end
         endcase
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         settle();
         case ($urandom_range(0, 5))
            0: coeff_word = 16'h8000;
            1: coeff_word = 16'h7FFF;
            2: coeff_word = 16'h0000;
            default: coeff_word = 16'($urandom);
         endcase
         case ($urandom_range(0, 7))
            0: dly = 11'd0;
            1: dly = 11'd1024;
            2: dly = 11'($urandom_range(1025, 2047));
            3: dly = 11'($urandom_range(1, 1024));
            default: dly = 11'($urandom_range(1, 16));
         endcase
         // last phase runs after the pointer has wrapped: full-length echo
         if (phase == NUM_PHASES - 1) dly = 11'd1024;
         write_reg(CSR_COEFF, coeff_word);
         write_reg(CSR_DELAY_LENGTH, {5'($urandom), dly});
         steady = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            mode = ($urandom_range(0, 9) == 0) ? MODE_TAP : MODE_FILTER;
            case ($urandom_range(0, 9))
               0: smp = 16'h8000;
               1: smp = 16'h7FFF;
               default: smp = 16'($urandom);
            endcase
            case ($urandom_range(0, 9))
               0: tap = 11'd0;
               1: tap = 11'($urandom_range(1025, 2047));
               2: tap = 11'($urandom_range(1, 1024));
               default: tap = 11'($urandom_range(1, 32));
            endcase
            if (phase == 3 && n == PHASE_ITEMS / 2) settle();
            send_item(mode, smp, tap, 1'b0, 16'h0000, steady ? 0 : idle_len());
         end
      end

      settle();
      $display("run covered %0d filter samples and %0d tap reads over %0d register writes",
               filter_count, tap_count, csr_writes);
      $display("%0d results checked, %0d mismatches", results_seen, errors);
      if (errors == 0 && pending_outputs.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/lap_pkg.sv
rtl/core/lap_ctrl.sv
rtl/core/lap_datapath.sv
rtl/core/lattice_allpass_filter_core.sv
bench/tb_top.sv
